// ===== sv/thermal_throttle_ladder_defines.svh =====
// Assertion macros shared by the checker of the thermal throttle ladder.
// Depends on nothing; the checker includes this file by its bare name.
`ifndef THERMAL_THROTTLE_LADDER_DEFINES_SVH
`define THERMAL_THROTTLE_LADDER_DEFINES_SVH

// Concurrent assertion on the rising clock edge, always evaluated.
`define TTL_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Concurrent assertion on the rising clock edge, switched off during reset.
`define TTL_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

// ===== sv/ttl_pkg.sv =====
// Package of the thermal throttle ladder: codes, types, reset values and helpers.
// Depends on nothing; used by ttl_step, thermal_throttle_ladder and ttl_checker.
package ttl_pkg;

  localparam int unsigned MAX_THROTTLE_STATES_DEF = 16;

  localparam logic [4:0]  THROTTLE_STATES_RST = 5'd8;
  localparam logic [23:0] FMAX_KHZ_RST        = 24'd2000000;
  localparam logic [1:0]  RED_MAX_STEP        = 2'd3;

  // floor(p / 5) == (p * DIV5_MUL) >> DIV5_SHIFT for every p below 2**27.
  localparam int unsigned PROD_W     = 27;
  localparam logic [26:0] DIV5_MUL   = 27'd107374183;
  localparam int unsigned DIV5_SHIFT = 29;

  typedef enum logic [1:0] {
    OP_RELEASE  = 2'd0,
    OP_INCREASE = 2'd1,
    OP_DECREASE = 2'd2,
    OP_SET_USER = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_THROTTLE_STATES = 2'd0,
    REG_THROTTLING_EN   = 2'd1,
    REG_FREQ_SCALING_EN = 2'd2,
    REG_FMAX            = 2'd3
  } reg_idx_t;

  localparam logic [1:0] STATUS_OK          = 2'd0;
  localparam logic [1:0] STATUS_REJECTED    = 2'd1;
  localparam logic [1:0] STATUS_UNSUPPORTED = 2'd2;

  typedef struct packed {
    logic [1:0] step;
    logic [3:0] thermal;
    logic [3:0] user;
    logic [3:0] applied;
  } ttl_state_t;

  typedef struct packed {
    logic [4:0] throttle_states;
    logic       throttling_en;
    logic       freq_scaling_en;
  } ttl_cfg_t;

  typedef struct packed {
    logic       at_limit;
    logic [1:0] status;
  } ttl_flags_t;

  function automatic logic [5:0] step_to_pct(input logic [1:0] step);
    logic [5:0] pct;
    unique case (step)
      2'd0:    pct = 6'd0;
      2'd1:    pct = 6'd20;
      2'd2:    pct = 6'd40;
      default: pct = 6'd60;
    endcase
    return pct;
  endfunction

  // Larger of the two limits, saturated to the last usable state.
  function automatic logic [3:0] clamp_limit(input logic [3:0] a, input logic [3:0] b,
                                             input logic [4:0] last);
    logic [3:0] t;
    t = (a > b) ? a : b;
    if ({1'b0, t} > last) begin
      t = last[3:0];
    end
    return t;
  endfunction

endpackage

// ===== sv/ttl_step.sv =====
// Combinational ladder update for one request of the thermal throttle ladder.
// Depends on ttl_pkg.
module ttl_step import ttl_pkg::*; #(
  parameter int unsigned MAX_THROTTLE_STATES = MAX_THROTTLE_STATES_DEF
) (
  input  logic [1:0] operation,
  input  logic [3:0] user_limit,
  input  ttl_cfg_t   cfg,
  input  ttl_state_t cur,
  output ttl_state_t nxt,
  output ttl_flags_t flags
);

  localparam int unsigned STATE_CAP = (MAX_THROTTLE_STATES > 31) ? 31 : MAX_THROTTLE_STATES;
  localparam logic [4:0]  CAP5      = STATE_CAP[4:0];

  logic [4:0] n_lim;
  logic [4:0] last;
  logic [3:0] tx;

  always_comb begin
    n_lim = (cfg.throttle_states > CAP5) ? CAP5 : cfg.throttle_states;
    last  = (n_lim == 5'd0) ? 5'd0 : n_lim - 5'd1;
  end

  always_comb begin
    nxt         = cur;
    flags       = '0;
    tx          = cur.thermal;
    if (op_t'(operation) == OP_SET_USER) begin
      if (!cfg.throttling_en) begin
        flags.status = STATUS_UNSUPPORTED;
      end else if ({1'b0, user_limit} > last) begin
        flags.status = STATUS_REJECTED;
      end else begin
        nxt.user    = user_limit;
        nxt.applied = clamp_limit(user_limit, cur.thermal, last);
      end
    end else begin
      // Thermal steps start from the state now applied.
      if (cfg.throttling_en) begin
        tx = cur.applied;
      end
      unique case (op_t'(operation))
        OP_RELEASE: begin
          if (cfg.freq_scaling_en) begin
            nxt.step = 2'd0;
          end
          tx = 4'd0;
        end
        OP_INCREASE: begin
          if (cfg.freq_scaling_en && cur.step < RED_MAX_STEP) begin
            nxt.step = cur.step + 2'd1;
          end else if (cfg.throttling_en) begin
            if ({1'b0, tx} >= last) begin
              flags.at_limit = 1'b1;
            end else begin
              tx = tx + 4'd1;
            end
          end else begin
            flags.at_limit = 1'b1;
          end
        end
        default: begin
          if (cfg.throttling_en && tx != 4'd0) begin
            tx = tx - 4'd1;
          end else if (cfg.freq_scaling_en && cur.step != 2'd0) begin
            nxt.step = cur.step - 2'd1;
          end else begin
            flags.at_limit = 1'b1;
          end
        end
      endcase
      if (cfg.throttling_en) begin
        nxt.thermal = tx;
        nxt.applied = clamp_limit(cur.user, tx, last);
      end
    end
  end

endmodule

// ===== sv/thermal_throttle_ladder.sv =====
// Top level of the thermal throttle ladder: ports, registers and the cap pipeline.
// Depends on ttl_pkg and ttl_step.
//
//  channel   direction  fields (lowest bit up)
//  s_*       in         tuser: operation[1:0]; tdata: user_limit[3:0]
//  m_*       out        tdata: applied, pct, cap, at_limit, status
//  cfg_*     in         cfg_index[1:0], cfg_data[23:0], always ready
//
// One request per cycle is taken unless a stalled output backs up the middle
// stage. A request's result passes the input stage and then the divide-by-five
// stage, whose register drives the output.
// Reset (rst, synchronous) clears the ladder state, loads the register
// defaults and empties both stages. A stalled output holds its result; the
// middle stage still takes one more request, and s_tready then stays low.
module thermal_throttle_ladder import ttl_pkg::*; #(
  parameter int unsigned MAX_THROTTLE_STATES = MAX_THROTTLE_STATES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // user_limit[3:0], zero pad [7:4]
  input  logic [1:0]  s_tuser,  // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // applied_throttle[3:0], reduction_percent[9:4],
                                // freq_cap_khz[33:10], at_limit[34], status[36:35],
                                // zero pad [39:37]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  // Configuration registers.
  ttl_cfg_t    cfg;
  logic [23:0] fmax_khz;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.throttle_states <= THROTTLE_STATES_RST;
      cfg.throttling_en   <= 1'b1;
      cfg.freq_scaling_en <= 1'b1;
      fmax_khz            <= FMAX_KHZ_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_THROTTLE_STATES: cfg.throttle_states <= cfg_data[4:0];
        REG_THROTTLING_EN:   cfg.throttling_en   <= cfg_data[0];
        REG_FREQ_SCALING_EN: cfg.freq_scaling_en <= cfg_data[0];
        default:             fmax_khz            <= cfg_data;
      endcase
    end
  end

  // The ladder state advances at the edge that accepts a request, so the
  // next request in the following cycle already sees the new state.
  ttl_state_t state;
  ttl_state_t state_next;
  ttl_flags_t flags;

  ttl_step #(
    .MAX_THROTTLE_STATES (MAX_THROTTLE_STATES)
  ) u_step (
    .operation  (s_tuser),
    .user_limit (s_tdata[3:0]),
    .cfg        (cfg),
    .cur        (state),
    .nxt        (state_next),
    .flags      (flags)
  );

  logic s_accept;
  logic out_free;
  logic s1_move;

  assign out_free = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (s_accept) begin
      state <= state_next;
    end
  end

  // Middle stage: result fields and fmax_khz * (5 - step), i.e. the cap times five.
  logic                s1_valid;
  logic [3:0]          s1_applied;
  logic [1:0]          s1_step;
  ttl_flags_t          s1_flags;
  logic [PROD_W-1:0]   s1_prod;
  logic [PROD_W-1:0]   prod_next;
  logic [PROD_W-1:0]   mf;

  assign s_tready = !s1_valid || out_free;
  assign s1_move  = s1_valid && out_free;
  assign mf       = {3'b000, fmax_khz};

  always_comb begin
    unique case (state_next.step)
      2'd0:    prod_next = (mf << 2) + mf;
      2'd1:    prod_next = mf << 2;
      2'd2:    prod_next = (mf << 1) + mf;
      default: prod_next = mf << 1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_applied <= state_next.applied;
      s1_step    <= state_next.step;
      s1_flags   <= flags;
      s1_prod    <= prod_next;
    end
  end

  // Output stage: divide by five through the reciprocal, then register.
  logic [2*PROD_W-1:0] recip_prod;
  logic [23:0]         cap_next;
  logic [3:0]          out_applied;
  logic [5:0]          out_pct;
  logic [23:0]         out_cap;
  ttl_flags_t          out_flags;

  assign recip_prod = {{PROD_W{1'b0}}, s1_prod} * {{PROD_W{1'b0}}, DIV5_MUL};
  assign cap_next   = recip_prod[DIV5_SHIFT +: 24];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_applied <= s1_applied;
      out_pct     <= step_to_pct(s1_step);
      out_cap     <= cap_next;
      out_flags   <= s1_flags;
    end
  end

  assign m_tdata = {3'b000, out_flags.status, out_flags.at_limit, out_cap, out_pct,
                    out_applied};

endmodule

// ===== sv/ttl_checker.sv =====
// Port-level checker of the thermal throttle ladder, bound to its top level.
// Depends on thermal_throttle_ladder_defines.svh and ttl_pkg (status codes).
`include "thermal_throttle_ladder_defines.svh"

module ttl_checker import ttl_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  // Nothing is offered in the cycle after a reset.
  `TTL_ASSERT(a_reset_empty, clk, rst |=> !m_tvalid, "result offered right after reset")

  // A held result keeps its value.
  `TTL_ASSERT_RST(a_hold, clk, rst, m_tvalid && !m_tready |=> $stable(m_tdata),
                  "stalled result changed")

  // With the output empty, the input side must take requests.
  `TTL_ASSERT_RST(a_ready, clk, rst, !m_tvalid |-> s_tready, "input stalled with empty output")

  // Saturation is only reported by thermal steps, which always answer ok.
  `TTL_ASSERT_RST(a_sat_ok, clk, rst, m_tvalid && m_tdata[34] |-> m_tdata[36:35] == STATUS_OK,
                  "saturated result with error status")

endmodule

bind thermal_throttle_ladder ttl_checker u_ttl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
